### hdl/hrb_pkg.sv
// ----------------------------------------------------------------------------
// hrb_pkg
// shared widths, constants and helpers for the haversine range and bearing
// pipeline
// ----------------------------------------------------------------------------
package hrb_pkg;

	// default fixed-point formats
	localparam int ANGLE_FRAC_BITS_DEF = 23;
	localparam int RANGE_FRAC_BITS_DEF = 16;

	// coordinate field widths
	localparam int LAT_W = 31;
	localparam int LON_W = 32;
	localparam int RES_W = 32;
	localparam int RADIUS_W = 16;
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd6371;

	// cordic
	localparam int CORDIC_ITERS = 32;
	localparam int TRIG_W = 32;   // q30 sine and cosine
	localparam int CX_W = 34;     // rotation datapath
	localparam int VIN_W = 34;    // vectoring operands
	localparam int VX_W = 36;     // vectoring datapath
	localparam int VZ_W = 35;     // vectoring angle accumulator
	localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
	localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
	localparam logic [30:0] Q30_ONE = 31'h4000_0000;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [31:0] HALF_TURN = 32'h8000_0000;

	// divide by 45 through reciprocal multiplies (exact over their ranges)
	localparam logic [32:0] DIV45_MUL = 33'd6108397933;
	localparam int DIV45_SHIFT = 38;
	localparam logic [20:0] DIV45S_MUL = 21'd1491309;
	localparam int DIV45S_SHIFT = 26;

	typedef logic signed [TRIG_W-1:0] trig_t;

	function automatic logic [31:0] atan_turns(input int idx);
		logic [31:0] v;
		case (idx)
			0: v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
			3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
			6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
			9: v = 32'h00145F2F;  10: v = 32'h000A2F98; 11: v = 32'h000517CC;
			12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
			15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
			18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
			21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
			24: v = 32'h00000029; 25: v = 32'h00000014; 26: v = 32'h0000000A;
			27: v = 32'h00000005; 28: v = 32'h00000003; 29: v = 32'h00000001;
			30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

	// q30 product, floor shift
	function automatic trig_t mulq30(input trig_t a, input trig_t b);
		logic signed [2*TRIG_W-1:0] p;
		p = a * b;
		return p[TRIG_W+29:30];
	endfunction

endpackage

### hdl/hrb_in_if.sv
// ----------------------------------------------------------------------------
// hrb_in_if
// input channel: two points as latitude and longitude
// ----------------------------------------------------------------------------
interface hrb_in_if;
	import hrb_pkg::*;

	logic valid;
	logic ready;
	logic signed [LAT_W-1:0] start_lat;
	logic signed [LON_W-1:0] start_lon;
	logic signed [LAT_W-1:0] end_lat;
	logic signed [LON_W-1:0] end_lon;

	modport source (output valid, output start_lat, output start_lon,
		output end_lat, output end_lon, input ready);
	modport sink (input valid, input start_lat, input start_lon,
		input end_lat, input end_lon, output ready);
endinterface

### hdl/hrb_out_if.sv
// ----------------------------------------------------------------------------
// hrb_out_if
// result channel: range and initial bearing
// ----------------------------------------------------------------------------
interface hrb_out_if;
	import hrb_pkg::*;

	logic valid;
	logic ready;
	logic [RES_W-1:0] range_out;
	logic [RES_W-1:0] bearing_out;

	modport source (output valid, output range_out, output bearing_out, input ready);
	modport sink (input valid, input range_out, input bearing_out, output ready);
endinterface

### hdl/hrb_sincos.sv
// ----------------------------------------------------------------------------
// hrb_sincos
// pipelined rotation cordic, one iteration per stage, binary angle in
// ----------------------------------------------------------------------------
module hrb_sincos (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [31:0]   angle,
	output logic          out_vld,
	output hrb_pkg::trig_t sin_val,
	output hrb_pkg::trig_t cos_val
);
	import hrb_pkg::*;

	localparam int N = CORDIC_ITERS;

	logic signed [CX_W-1:0] x_s [0:N];
	logic signed [CX_W-1:0] y_s [0:N];
	logic signed [CX_W-1:0] z_s [0:N];
	logic                   flip_s [0:N];
	logic                   vld_s [0:N];

	logic [31:0] turn_plus;
	logic [31:0] turn_adj;
	logic        flip_in;

	// fold the left half plane onto the right one
	always_comb begin
		turn_plus = angle + QUARTER_TURN;
		flip_in = turn_plus[31];
		turn_adj = flip_in ? angle + HALF_TURN : angle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= CX_W'(CORDIC_GAIN_Q30);
			y_s[0] <= '0;
			z_s[0] <= {{(CX_W-32){turn_adj[31]}}, turn_adj};
			flip_s[0] <= flip_in;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		logic signed [CX_W-1:0] dx;
		logic signed [CX_W-1:0] dy;
		logic signed [CX_W-1:0] step;

		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		assign step = {{(CX_W-32){1'b0}}, atan_turns(i)};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][CX_W-1]) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - step;
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + step;
				end
				flip_s[i+1] <= flip_s[i];
			end
		end
	end

	logic signed [CX_W-1:0] sin_full;
	logic signed [CX_W-1:0] cos_full;

	assign sin_full = flip_s[N] ? -y_s[N] : y_s[N];
	assign cos_full = flip_s[N] ? -x_s[N] : x_s[N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= vld_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sin_val <= sin_full[TRIG_W-1:0];
			cos_val <= cos_full[TRIG_W-1:0];
		end
	end

endmodule

### hdl/hrb_atan2.sv
// ----------------------------------------------------------------------------
// hrb_atan2
// pipelined vectoring cordic, one iteration per stage, binary angle out
// ----------------------------------------------------------------------------
module hrb_atan2 (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_vld,
	input  logic signed [hrb_pkg::VIN_W-1:0] y_in,
	input  logic signed [hrb_pkg::VIN_W-1:0] x_in,
	output logic                           out_vld,
	output logic signed [hrb_pkg::VZ_W-1:0]  angle
);
	import hrb_pkg::*;

	localparam int N = CORDIC_ITERS;

	logic signed [VX_W-1:0] x_s [0:N];
	logic signed [VX_W-1:0] y_s [0:N];
	logic signed [VZ_W-1:0] z_s [0:N];
	logic                   zero_s [0:N];
	logic                   vld_s [0:N];

	logic signed [VX_W-1:0] x_ext;
	logic signed [VX_W-1:0] y_ext;

	assign x_ext = {{(VX_W-VIN_W){x_in[VIN_W-1]}}, x_in};
	assign y_ext = {{(VX_W-VIN_W){y_in[VIN_W-1]}}, y_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	// left half plane: negate both and start from half a turn
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (x_in == '0) && (y_in == '0);
			if (x_in[VIN_W-1]) begin
				x_s[0] <= -x_ext;
				y_s[0] <= -y_ext;
				z_s[0] <= {{(VZ_W-32){1'b0}}, HALF_TURN};
			end else begin
				x_s[0] <= x_ext;
				y_s[0] <= y_ext;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		logic signed [VX_W-1:0] dx;
		logic signed [VX_W-1:0] dy;
		logic signed [VZ_W-1:0] step;

		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		assign step = {{(VZ_W-32){1'b0}}, atan_turns(i)};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_s[i][VX_W-1]) begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + step;
				end else begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - step;
				end
				zero_s[i+1] <= zero_s[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= vld_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle <= zero_s[N] ? '0 : z_s[N];
		end
	end

endmodule

### hdl/haversine_range_bearing.sv
// ----------------------------------------------------------------------------
// haversine_range_bearing
// great-circle range and initial bearing between two points, fixed-point
// cordic trig, atan2 and square root in one stall-able pipeline
// ----------------------------------------------------------------------------
//
// channel   dir   handshake      payload
// in_ch     in    valid/ready    start_lat, start_lon, end_lat, end_lon
// out_ch    out   valid/ready    range_out, bearing_out
// cfg       in    cfg_we         cfg_wdata -> earth radius in km
//
// one beat accepted per clock while the result queue has room; the path from input
// beat to result beat runs through the two 32-stage cordic pipelines and the 31-stage root
// arst_n clears the valid bits, the result queue and loads the radius with 6371
// a two-entry result queue sits at the end; the pipeline only freezes when
// both entries are held, and ready toward the source follows that alone
//
module haversine_range_bearing #(
	parameter int ANGLE_FRAC_BITS = hrb_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int RANGE_FRAC_BITS = hrb_pkg::RANGE_FRAC_BITS_DEF
) (
	input logic                           clk,
	input logic                           arst_n,
	hrb_in_if.sink                        in_ch,
	hrb_out_if.source                     out_ch,
	input logic                           cfg_we,
	input logic [hrb_pkg::RADIUS_W-1:0]   cfg_wdata
);
	import hrb_pkg::*;

	// degree to turn conversion: d * 2^TURN_SH / 360 = (d/45 and rest) << SUB_SH
	localparam int TURN_SH = 32 - ANGLE_FRAC_BITS;
	localparam int SUB_SH = TURN_SH - 3;
	localparam int RNG_SH = 32 - RANGE_FRAC_BITS;
	localparam int Q1_W = 27;
	localparam int P1_W = 65;
	localparam int P2_W = 6 + SUB_SH + 21;
	localparam int TURN_W = 33;
	localparam int NCOORD = 4;
	localparam int NANGLE = 5;
	localparam int ISQ_W = 61;
	localparam int ISQ_N = (ISQ_W + 1) / 2;
	localparam int RAD_W = 36;
	localparam int RPROD_W = RADIUS_W + RAD_W;

	// coordinate lanes
	localparam int C_LAT1 = 0;
	localparam int C_LON1 = 1;
	localparam int C_LAT2 = 2;
	localparam int C_LON2 = 3;
	// trig lanes
	localparam int A_LAT1 = 0;
	localparam int A_LAT2 = 1;
	localparam int A_HLAT = 2;
	localparam int A_HLON = 3;
	localparam int A_DLON = 4;

	typedef struct packed {
		logic [RES_W-1:0] rng;
		logic [RES_W-1:0] brg;
	} res_t;

	typedef struct packed {
		logic [ISQ_W-1:0] rem;
		logic [ISQ_W-1:0] root;
	} isq_t;

	// one step of the bitwise integer root
	function automatic isq_t isq_step(input isq_t cur, input logic [ISQ_W-1:0] bitv);
		isq_t nxt;
		logic [ISQ_W:0] trial;
		trial = {1'b0, cur.root} + {1'b0, bitv};
		if ({1'b0, cur.rem} >= trial) begin
			nxt.rem = cur.rem - trial[ISQ_W-1:0];
			nxt.root = (cur.root >> 1) + bitv;
		end else begin
			nxt.rem = cur.rem;
			nxt.root = cur.root >> 1;
		end
		return nxt;
	endfunction

	// --------------------------------------------------------------------
	// flow control and radius register
	// --------------------------------------------------------------------
	logic [1:0] cnt_q;
	logic       en;

	assign en = (cnt_q != 2'd2);
	assign in_ch.ready = en;

	logic [RADIUS_W-1:0] radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (cfg_we) begin
			radius_q <= cfg_wdata;
		end
	end

	// --------------------------------------------------------------------
	// s1..s5: degrees to binary angle, modulo 2^33
	// --------------------------------------------------------------------
	logic signed [31:0] coord_in [0:NCOORD-1];

	assign coord_in[C_LAT1] = {in_ch.start_lat[LAT_W-1], in_ch.start_lat};
	assign coord_in[C_LON1] = in_ch.start_lon;
	assign coord_in[C_LAT2] = {in_ch.end_lat[LAT_W-1], in_ch.end_lat};
	assign coord_in[C_LON2] = in_ch.end_lon;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	logic [TURN_W-1:0] turn_s5 [0:NCOORD-1];

	for (genvar c = 0; c < NCOORD; c++) begin : g_coord
		logic [31:0]        mag_in;
		logic [31:0]        mag_s1, mag_s2;
		logic               neg_s1, neg_s2, neg_s3, neg_s4;
		logic [P1_W-1:0]    p1;
		logic [Q1_W-1:0]    q1_s2, q1_s3, q1_s4;
		logic [31:0]        q1x45;
		logic [5:0]         rem_s3;
		logic [P2_W-1:0]    p2;
		logic [SUB_SH-1:0]  q2_s4;
		logic [Q1_W+SUB_SH-1:0] full;

		// magnitude, truncation toward zero is done on it
		assign mag_in = coord_in[c][31] ? 32'(-coord_in[c]) : coord_in[c];
		assign p1 = P1_W'(mag_s1) * P1_W'(DIV45_MUL);
		assign q1x45 = 32'(q1_s2) * 32'd45;
		assign p2 = P2_W'({rem_s3, {SUB_SH{1'b0}}}) * P2_W'(DIV45S_MUL);
		assign full = {q1_s4, q2_s4};

		always_ff @(posedge clk) begin
			if (en) begin
				mag_s1 <= mag_in;
				neg_s1 <= coord_in[c][31];
				q1_s2 <= p1[DIV45_SHIFT+Q1_W-1:DIV45_SHIFT];
				mag_s2 <= mag_s1;
				neg_s2 <= neg_s1;
				rem_s3 <= 6'(mag_s2 - q1x45);
				q1_s3 <= q1_s2;
				neg_s3 <= neg_s2;
				q2_s4 <= p2[DIV45S_SHIFT+SUB_SH-1:DIV45S_SHIFT];
				q1_s4 <= q1_s3;
				neg_s4 <= neg_s3;
				turn_s5[c] <= neg_s4 ? -full[TURN_W-1:0] : full[TURN_W-1:0];
			end
		end
	end

	// --------------------------------------------------------------------
	// five rotation cordics
	// --------------------------------------------------------------------
	logic [TURN_W-1:0] dlat;
	logic [TURN_W-1:0] dlon;
	logic [31:0]       ang [0:NANGLE-1];

	assign dlat = turn_s5[C_LAT2] - turn_s5[C_LAT1];
	assign dlon = turn_s5[C_LON2] - turn_s5[C_LON1];
	assign ang[A_LAT1] = turn_s5[C_LAT1][31:0];
	assign ang[A_LAT2] = turn_s5[C_LAT2][31:0];
	assign ang[A_HLAT] = dlat[TURN_W-1:1];
	assign ang[A_HLON] = dlon[TURN_W-1:1];
	assign ang[A_DLON] = dlon[31:0];

	trig_t             sin_w [0:NANGLE-1];
	trig_t             cos_w [0:NANGLE-1];
	logic [NANGLE-1:0] sc_vld;

	for (genvar k = 0; k < NANGLE; k++) begin : g_trig
		hrb_sincos u_sincos (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.in_vld  (v_s5),
			.angle   (ang[k]),
			.out_vld (sc_vld[k]),
			.sin_val (sin_w[k]),
			.cos_val (cos_w[k])
		);
	end

	// --------------------------------------------------------------------
	// s6, s7: q30 products for the haversine term and the bearing operands
	// --------------------------------------------------------------------
	logic  v_s6, v_s7;
	trig_t hl2_s6, c12_s6, hn2_s6, by_s6, c1s2_s6, s1c2_s6, cdn_s6;
	trig_t hl2_s7, ch_s7, sc_s7, by_s7, c1s2_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s6 <= &sc_vld;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hl2_s6 <= mulq30(sin_w[A_HLAT], sin_w[A_HLAT]);
			c12_s6 <= mulq30(cos_w[A_LAT1], cos_w[A_LAT2]);
			hn2_s6 <= mulq30(sin_w[A_HLON], sin_w[A_HLON]);
			by_s6 <= mulq30(sin_w[A_DLON], cos_w[A_LAT2]);
			c1s2_s6 <= mulq30(cos_w[A_LAT1], sin_w[A_LAT2]);
			s1c2_s6 <= mulq30(sin_w[A_LAT1], cos_w[A_LAT2]);
			cdn_s6 <= cos_w[A_DLON];
			ch_s7 <= mulq30(c12_s6, hn2_s6);
			sc_s7 <= mulq30(s1c2_s6, cdn_s6);
			hl2_s7 <= hl2_s6;
			by_s7 <= by_s6;
			c1s2_s7 <= c1s2_s6;
		end
	end

	// --------------------------------------------------------------------
	// s8 onward: clamp, two integer roots, bearing operands delayed alongside
	// --------------------------------------------------------------------
	logic signed [TRIG_W:0] a_sum;
	logic [30:0]            a_clamp;
	logic signed [TRIG_W:0] bx_w;

	assign a_sum = {hl2_s7[TRIG_W-1], hl2_s7} + {ch_s7[TRIG_W-1], ch_s7};
	assign bx_w = {c1s2_s7[TRIG_W-1], c1s2_s7} - {sc_s7[TRIG_W-1], sc_s7};

	// a held to [0, 1] in q30
	always_comb begin
		if (a_sum[TRIG_W]) begin
			a_clamp = '0;
		end else if (a_sum > $signed({2'b00, Q30_ONE})) begin
			a_clamp = Q30_ONE;
		end else begin
			a_clamp = a_sum[30:0];
		end
	end

	isq_t                    ra_s [0:ISQ_N];
	isq_t                    rb_s [0:ISQ_N];
	logic signed [VIN_W-1:0] bx_s [0:ISQ_N];
	logic signed [VIN_W-1:0] by_s [0:ISQ_N];
	logic                    isq_vld_s [0:ISQ_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			isq_vld_s[0] <= 1'b0;
		end else if (en) begin
			isq_vld_s[0] <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ra_s[0].rem <= {a_clamp, 30'b0};
			ra_s[0].root <= '0;
			rb_s[0].rem <= {Q30_ONE - a_clamp, 30'b0};
			rb_s[0].root <= '0;
			bx_s[0] <= {bx_w[TRIG_W], bx_w};
			by_s[0] <= {{(VIN_W-TRIG_W){by_s7[TRIG_W-1]}}, by_s7};
		end
	end

	for (genvar j = 0; j < ISQ_N; j++) begin : g_isq
		localparam logic [ISQ_W-1:0] BITV = ISQ_W'(1) << (ISQ_W - 1 - 2 * j);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				isq_vld_s[j+1] <= 1'b0;
			end else if (en) begin
				isq_vld_s[j+1] <= isq_vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ra_s[j+1] <= isq_step(ra_s[j], BITV);
				rb_s[j+1] <= isq_step(rb_s[j], BITV);
				bx_s[j+1] <= bx_s[j];
				by_s[j+1] <= by_s[j];
			end
		end
	end

	// --------------------------------------------------------------------
	// two vectoring cordics: central half angle and bearing
	// --------------------------------------------------------------------
	logic signed [VIN_W-1:0] ra_in;
	logic signed [VIN_W-1:0] rb_in;
	logic signed [VZ_W-1:0]  z_rng;
	logic signed [VZ_W-1:0]  z_brg;
	logic                    rng_vld;
	logic                    brg_vld;

	assign ra_in = {{(VIN_W-31){1'b0}}, ra_s[ISQ_N].root[30:0]};
	assign rb_in = {{(VIN_W-31){1'b0}}, rb_s[ISQ_N].root[30:0]};

	hrb_atan2 u_atan_rng (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (isq_vld_s[ISQ_N]),
		.y_in    (ra_in),
		.x_in    (rb_in),
		.out_vld (rng_vld),
		.angle   (z_rng)
	);

	hrb_atan2 u_atan_brg (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (isq_vld_s[ISQ_N]),
		.y_in    (by_s[ISQ_N]),
		.x_in    (bx_s[ISQ_N]),
		.out_vld (brg_vld),
		.angle   (z_brg)
	);

	// --------------------------------------------------------------------
	// s9..s11: angle to radians and km, bearing to degrees
	// --------------------------------------------------------------------
	logic                 v_s9, v_s10, v_s11;
	logic [32:0]          cang_s9;
	logic [31:0]          bt_s9;
	logic [RAD_W-1:0]     rad_s10;
	logic [RES_W-1:0]     bear_s10, bear_s11;
	logic [RPROD_W-1:0]   rprod_s11;
	logic [64:0]          rad_prod;
	logic [40:0]          bear_prod;
	logic [RPROD_W-1:0]   rng_shift;
	logic [RES_W-1:0]     rng_sat;

	assign rad_prod = 65'(cang_s9) * 65'(TWO_PI_Q29);
	assign bear_prod = 41'(bt_s9) * 41'd360;
	assign rng_shift = rprod_s11 >> RNG_SH;
	assign rng_sat = (|rng_shift[RPROD_W-1:RES_W]) ? '1 : rng_shift[RES_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s9 <= rng_vld & brg_vld;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// doubled half angle, negative held at zero
			cang_s9 <= z_rng[VZ_W-1] ? '0 : {z_rng[31:0], 1'b0};
			bt_s9 <= z_brg[31:0];
			rad_s10 <= rad_prod[29+RAD_W-1:29];
			bear_s10 <= RES_W'(bear_prod >> TURN_SH);
			rprod_s11 <= RPROD_W'(radius_q) * RPROD_W'(rad_s10);
			bear_s11 <= bear_s10;
		end
	end

	// --------------------------------------------------------------------
	// two-entry result queue
	// --------------------------------------------------------------------
	res_t fifo_q [0:1];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic push;
	logic pop;

	assign push = en & v_s11;
	assign pop = out_ch.valid & out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{rng: rng_sat, brg: bear_s11};
		end
	end

	assign out_ch.valid = (cnt_q != 2'd0);
	assign out_ch.range_out = fifo_q[rd_ptr_q].rng;
	assign out_ch.bearing_out = fifo_q[rd_ptr_q].brg;

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the haversine range and bearing pipeline: a
// directed table, then random point pairs under several radius settings,
// each result checked against a bit-exact fixed-point predictor
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import hrb_pkg::*;

	// coordinate limits in degrees times 2^23
	localparam logic signed [LAT_W-1:0] LAT_MAX = 31'sd754974720;
	localparam logic signed [LON_W-1:0] LON_MAX = 32'sd1509949440;
	localparam int IDLE_LIMIT = 4000;     // cycles with no beat on either side
	localparam int CHOKE_CYCLES = 400;    // long receiver hold-off
	localparam int RANDOM_ITEMS = 700;

	// arctangent of 2^-i in binary-angle units
	localparam logic [31:0] ATAN_TAB [0:31] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};

	typedef struct packed {
		logic [RES_W-1:0] range_km;
		logic [RES_W-1:0] bearing_deg;
	} fix_t;

	// directed row: radius to use, two points, optional typed range
	typedef struct {
		int unsigned radius;
		logic signed [LAT_W-1:0] lat1;
		logic signed [LON_W-1:0] lon1;
		logic signed [LAT_W-1:0] lat2;
		logic signed [LON_W-1:0] lon2;
		bit range_known;
		logic [RES_W-1:0] range_val;
	} probe_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [RADIUS_W-1:0] cfg_wdata = '0;

	hrb_in_if in_ch();
	hrb_out_if out_ch();

	haversine_range_bearing dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		in_ch.valid = 1'b0;
		in_ch.start_lat = '0;
		in_ch.start_lon = '0;
		in_ch.end_lat = '0;
		in_ch.end_lon = '0;
		out_ch.ready = 1'b0;
	end

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// fixed-point predictor
	// ------------------------------------------------------------------------
	logic [RADIUS_W-1:0] radius_km = RADIUS_RESET;   // mirror of the radius register
	fix_t pending_fixes [$];
	int mismatches = 0;
	int faults = 0;
	bit calm = 1'b0;          // no idling on either side while set
	bit choke_req = 1'b0;

	// degrees times 2^23 to binary angle, truncating toward zero
	function automatic longint deg_turns(input longint d);
		return (d * 512) / 360;
	endfunction

	// rotation mode cordic, q30 sine and cosine
	function automatic void rot_sincos(input logic [31:0] t, output longint s,
			output longint c);
		logic [31:0] tq;
		bit flip;
		longint x, y, z, dx, dy;
		tq = t + QUARTER_TURN;
		flip = tq[31];
		x = longint'(CORDIC_GAIN_Q30);
		y = 0;
		if (flip) begin
			t = t + HALF_TURN;
		end
		z = longint'($signed(t));
		for (int i = 0; i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN_TAB[i];
			end else begin
				x += dx; y -= dy; z += ATAN_TAB[i];
			end
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	// vectoring mode cordic, angle in binary-angle units
	function automatic longint vec_angle(input longint y, input longint x);
		longint z, dx, dy;
		z = 0;
		if (x == 0 && y == 0) begin
			return 0;
		end
		if (x < 0) begin
			x = -x; y = -y; z = 64'sd1 << 31;
		end
		for (int i = 0; i < 32; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += ATAN_TAB[i];
			end else begin
				x -= dx; y += dy; z -= ATAN_TAB[i];
			end
		end
		return z;
	endfunction

	function automatic longint q30_mul(input longint a, input longint b);
		return (a * b) >>> 30;
	endfunction

	function automatic longint unsigned int_root(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic fix_t range_bearing_of(input logic [RADIUS_W-1:0] rkm,
			input logic signed [LAT_W-1:0] la1, input logic signed [LON_W-1:0] lo1,
			input logic signed [LAT_W-1:0] la2, input logic signed [LON_W-1:0] lo2);
		longint t_la1, t_lo1, t_la2, t_lo2, dlat, dlon;
		longint s1, c1, s2, c2, shl, chl, shn, chn, sdn, cdn;
		longint hav, ra, rb, z, bx, by;
		longint unsigned cang, rad, rng, bscaled;
		logic [31:0] bt;
		fix_t f;
		t_la1 = deg_turns(longint'(la1));
		t_lo1 = deg_turns(longint'(lo1));
		t_la2 = deg_turns(longint'(la2));
		t_lo2 = deg_turns(longint'(lo2));
		dlat = t_la2 - t_la1;
		dlon = t_lo2 - t_lo1;
		rot_sincos(t_la1[31:0], s1, c1);
		rot_sincos(t_la2[31:0], s2, c2);
		rot_sincos(dlat[32:1], shl, chl);
		rot_sincos(dlon[32:1], shn, chn);
		rot_sincos(dlon[31:0], sdn, cdn);

		// haversine term, clamped to [0,1] in q30
		hav = q30_mul(shl, shl) + q30_mul(q30_mul(c1, c2), q30_mul(shn, shn));
		if (hav < 0) hav = 0;
		if (hav > (64'sd1 << 30)) hav = 64'sd1 << 30;
		ra = longint'(int_root(longint'(hav) << 30));
		rb = longint'(int_root(((64'sd1 << 30) - hav) << 30));
		z = 2 * vec_angle(ra, rb);
		if (z < 0) z = 0;
		cang = z;
		rad = (cang * TWO_PI_Q29) >> 29;
		rng = (longint'(rkm) * rad) >> 16;
		f.range_km = (rng > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rng[31:0];

		by = q30_mul(sdn, c2);
		bx = q30_mul(c1, s2) - q30_mul(q30_mul(s1, c2), cdn);
		bt = 32'(vec_angle(by, bx));
		bscaled = (longint'(bt) * 360) >> 9;
		f.bearing_deg = bscaled[31:0];
		return f;
	endfunction

	// ------------------------------------------------------------------------
	// input beat capture, result checking, watchdog
	// ------------------------------------------------------------------------
	bit typed_range = 1'b0;          // set by the driver for directed rows
	logic [RES_W-1:0] typed_val = '0;
	int idle_cycles = 0;

	always @(posedge clk) begin
		fix_t f;
		if (in_ch.valid && in_ch.ready) begin
			f = range_bearing_of(radius_km, in_ch.start_lat, in_ch.start_lon,
				in_ch.end_lat, in_ch.end_lon);
			if (typed_range) begin
				f.range_km = typed_val;
			end
			pending_fixes.push_back(f);
		end
	end

	always @(posedge clk) begin
		fix_t want;
		if (out_ch.valid && out_ch.ready) begin
			if (pending_fixes.size() == 0) begin
				faults++;
				if (mismatches + faults <= 10) begin
					$display("unexpected result beat range=%h bearing=%h",
						out_ch.range_out, out_ch.bearing_out);
				end
			end else begin
				want = pending_fixes.pop_front();
				if (out_ch.range_out !== want.range_km ||
						out_ch.bearing_out !== want.bearing_deg) begin
					mismatches++;
					if (mismatches + faults <= 10) begin
						$display("mismatch range exp=%h got=%h bearing exp=%h got=%h",
							want.range_km, out_ch.range_out,
							want.bearing_deg, out_ch.bearing_out);
					end
				end
			end
		end
	end

	// a long quiet stretch means the pipeline has hung
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// receiver: random stalls, plus one long hold-off on request
	// ------------------------------------------------------------------------
	function automatic int gap_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (calm || pick < 65) return 0;
		if (pick < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	initial begin
		int hold;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (choke_req) begin
				choke_req = 1'b0;
				hold = CHOKE_CYCLES;
			end
			if (hold > 0) begin
				out_ch.ready <= 1'b0;
				hold--;
			end else if (gap_len() == 0) begin
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// sender
	// ------------------------------------------------------------------------
	task automatic send_pair(input logic signed [LAT_W-1:0] la1,
			input logic signed [LON_W-1:0] lo1, input logic signed [LAT_W-1:0] la2,
			input logic signed [LON_W-1:0] lo2, input bit known,
			input logic [RES_W-1:0] rval);
		int g;
		g = gap_len();
		if (g > 0) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
			repeat (g - 1) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.start_lat <= la1;
		in_ch.start_lon <= lo1;
		in_ch.end_lat <= la2;
		in_ch.end_lon <= lo2;
		typed_range <= known;
		typed_val <= rval;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// radius changes only once every result is home
	task automatic set_radius(input logic [RADIUS_W-1:0] r);
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pending_fixes.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= r;
		@(negedge clk);
		cfg_we <= 1'b0;
		radius_km = r;
	endtask

	function automatic logic signed [LAT_W-1:0] rand_lat();
		if ($urandom_range(0, 9) == 0) return LAT_W'($urandom());
		return LAT_W'($signed($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX);
	endfunction

	function automatic logic signed [LON_W-1:0] rand_lon();
		if ($urandom_range(0, 9) == 0) return $urandom();
		return LON_W'($signed(64'($urandom_range(0, 32'hFFFF_FFFF) % 3019898881)
			- LON_MAX));
	endfunction

	probe_t probes [$];

	initial begin
		logic signed [LAT_W-1:0] la1, la2;
		logic signed [LON_W-1:0] lo1, lo2;
		int unsigned radii [5];

		// directed rows: coincident points, poles, dateline, extremes,
		// zero radius, saturating range
		probes = '{
			'{6371, 0, 0, 0, 0, 0, 0},
			'{6371, 0, 0, 0, 32'sd83886080, 0, 0},
			'{6371, 0, 0, LAT_MAX, 0, 0, 0},
			'{6371, LAT_MAX, 0, -LAT_MAX, 0, 0, 0},
			'{6371, 0, -LON_MAX, 0, LON_MAX, 0, 0},
			'{6371, 0, 0, 0, LON_MAX, 0, 0},
			'{6371, -LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX, 0, 0},
			'{6371, 31'sd400000000, 32'sd700000000, 31'sd400000000, 32'sd700000000, 0, 0},
			'{6371, 31'sd400000000, 32'sd700000000, 31'sd400000001, 32'sd700000003, 0, 0},
			'{6371, 31'sh3FFF_FFFF, 32'sh7FFF_FFFF, 31'sh4000_0000, 32'sh8000_0000, 0, 0},
			'{6371, -31'sd300000000, 32'sd100000000, 31'sd250000000, -32'sd900000000, 0, 0},
			'{0, 0, 0, 0, LON_MAX, 1, 0},
			'{0, LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX, 1, 0},
			'{0, 31'sd123456789, -32'sd987654321, -31'sd55555555, 32'sd44444444, 1, 0},
			'{65535, 0, 0, 0, LON_MAX, 1, 32'hFFFF_FFFF},
			'{65535, 0, 0, 0, 32'sd754974720, 1, 32'hFFFF_FFFF},
			'{65535, 0, 0, 0, 32'sd8388608, 0, 0},
			'{1, 0, 0, 0, LON_MAX, 0, 0},
			'{1, -LAT_MAX, 0, LAT_MAX, 32'sd1000, 0, 0},
			'{1, 31'sd1, -32'sd1, -31'sd1, 32'sd1, 0, 0}
		};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset value of the radius register is checked by the first rows
		foreach (probes[i]) begin
			if (probes[i].radius != radius_km) begin
				set_radius(RADIUS_W'(probes[i].radius));
			end
			send_pair(probes[i].lat1, probes[i].lon1, probes[i].lat2, probes[i].lon2,
				probes[i].range_known, probes[i].range_val);
		end

		// random phases, one radius each
		radii = '{65535, 6371, 1, 0, 0};
		radii[4] = $urandom_range(1, 65535);
		for (int ph = 0; ph < 5; ph++) begin
			set_radius(RADIUS_W'(radii[ph]));
			for (int n = 0; n < RANDOM_ITEMS / 5; n++) begin
				calm = (n >= 60 && n < 90);
				if (ph == 1 && n == 100) choke_req = 1'b1;
				la1 = rand_lat();
				lo1 = rand_lon();
				case ($urandom_range(0, 9))
					0: begin
						la2 = la1; lo2 = lo1;
					end
					1, 2: begin
						la2 = LAT_W'(la1 + $signed($urandom_range(0, 2000)) - 1000);
						lo2 = lo1 + $signed($urandom_range(0, 2000)) - 1000;
					end
					3: begin
						la2 = -la1; lo2 = lo1 + 32'sh5A00_0000;
					end
					default: begin
						la2 = rand_lat(); lo2 = rand_lon();
					end
				endcase
				send_pair(la1, lo1, la2, lo2, 1'b0, '0);
			end
		end
		calm = 1'b0;

		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pending_fixes.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		if (mismatches == 0 && faults == 0 && pending_fixes.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

### files.f
hdl/hrb_pkg.sv
hdl/hrb_in_if.sv
hdl/hrb_out_if.sv
hdl/hrb_sincos.sv
hdl/hrb_atan2.sv
hdl/haversine_range_bearing.sv
tb/sv/tb_top.sv
